### rtl/clcd_pkg.sv
package clcd_pkg;

  localparam logic [7:0] CMD_LEAD   = 8'h7E;
  localparam logic [7:0] CMD_POS    = 8'h24;
  localparam logic [7:0] CMD_LEN    = 8'h26;
  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] UNDERSCORE = 8'h5F;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_SEND  = 2'd2;

  localparam logic [1:0] CFG_COLS = 2'd0;
  localparam logic [1:0] CFG_ROWS = 2'd1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BASE,
    ST_WRITE,
    ST_HEAD,
    ST_ROW
  } clcd_state_t;

  // Position within the six-byte command header of a row transfer.
  typedef enum logic [2:0] {
    HD_LEAD0,
    HD_POS,
    HD_BASE,
    HD_LEAD1,
    HD_LEN,
    HD_WIDTH
  } clcd_head_t;

  function automatic logic [7:0] clcd_glyph(input logic [7:0] c);
    logic [7:0] g;
    g = SPACE_CHAR;
    if (c >= 8'd32 && c <= 8'd126) begin
      if (c == 8'd92) begin
        g = SPACE_CHAR;
      end else if (c == 8'd126) begin
        g = UNDERSCORE;
      end else begin
        g = c;
      end
    end else if ((c >= 8'd224 && c <= 8'd229) || c == 8'd236 || c == 8'd238 ||
                 c == 8'd239 || (c >= 8'd242 && c <= 8'd247) || c == 8'd253) begin
      g = c;
    end
    return g;
  endfunction

endpackage

### rtl/clcd_frame_ram.sv
module clcd_frame_ram #(
  parameter int Depth = 64,
  parameter int AddrW = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [7:0]       wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [7:0]       rdata
);

  logic [7:0] mem [Depth];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/char_lcd_frame_serializer.sv
// Character display frame store with a serial command emitter. A write request
// stores the translated glyph at a 1-based column and row: the row offset is
// built by adding the width once for each row above it in the single shared
// address adder. A send request first builds the offset the same way, then
// emits 6 + width bytes, one per cycle while out_stall is low, read from the
// frame memory. A clear request, and the pass that follows reset, write spaces
// to the frame memory one entry per cycle; no request is taken while it runs,
// while configuration writes are always taken. The store is laid out row after
// row with a pitch equal to the width in use, so change the size only between
// frames.
module char_lcd_frame_serializer #(
  parameter int MAX_COLS = 16,
  parameter int MAX_ROWS = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_kind,
  input  logic [5:0] in_column,
  input  logic [2:0] in_line,
  input  logic [7:0] in_char_code,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [4:0] cfg_wdata
);
  import clcd_pkg::*;

  localparam int Depth = MAX_COLS * MAX_ROWS;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int PtrW  = $clog2(Depth + 1);
  localparam int ColW  = $clog2(MAX_COLS + 1);
  localparam int RowW  = $clog2(MAX_ROWS + 1);

  clcd_state_t state_r, state_nxt;
  clcd_head_t  head_r, head_nxt;

  logic [4:0]      cols_r;
  logic [2:0]      rows_r;
  logic [PtrW-1:0] ptr_r, ptr_nxt;
  logic [2:0]      cnt_r, cnt_nxt;
  logic [ColW-1:0] cidx_r, cidx_nxt;
  logic            send_r, send_nxt;
  logic [5:0]      col_r, col_nxt;
  logic [7:0]      code_r, code_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      out_byte_r, out_byte_nxt;
  logic            out_last_r, out_last_nxt;

  logic [ColW-1:0] w_s;
  logic [RowW-1:0] h_s;
  logic [PtrW-1:0] addend_s;
  logic [PtrW-1:0] sum_s;
  logic            slot_free;
  logic            accept;
  logic            line_ok;
  logic            col_ok;

  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [7:0]       ram_wdata;
  logic [7:0]       ram_rdata;

  // Size in use, saturated to the range the store can hold.
  always_comb begin
    if (cols_r == '0) begin
      w_s = ColW'(1);
    end else if (int'(cols_r) > MAX_COLS) begin
      w_s = ColW'(MAX_COLS);
    end else begin
      w_s = ColW'(cols_r);
    end
    if (rows_r == '0) begin
      h_s = RowW'(1);
    end else if (int'(rows_r) > MAX_ROWS) begin
      h_s = RowW'(MAX_ROWS);
    end else begin
      h_s = RowW'(rows_r);
    end
  end

  assign line_ok   = (in_line != '0) && (int'(in_line) <= int'(h_s));
  assign col_ok    = (in_column != '0) && (int'(in_column) <= int'(w_s));
  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  // The one adder shared by offset build, write address, row read and sweep.
  always_comb begin
    case (state_r)
      ST_BASE:  addend_s = PtrW'(w_s);
      ST_WRITE: addend_s = PtrW'(col_r - 6'd1);
      default:  addend_s = PtrW'(1);
    endcase
  end
  assign sum_s = ptr_r + addend_s;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    ptr_nxt       = ptr_r;
    cnt_nxt       = cnt_r;
    cidx_nxt      = cidx_r;
    send_nxt      = send_r;
    col_nxt       = col_r;
    code_nxt      = code_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    ram_we        = 1'b0;
    ram_waddr     = ptr_r[AddrW-1:0];
    ram_wdata     = SPACE_CHAR;

    unique case (state_r)
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (int'(ptr_r) == Depth - 1) begin
          ptr_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          ptr_nxt = sum_s;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          col_nxt  = in_column;
          code_nxt = in_char_code;
          cnt_nxt  = in_line - 3'd1;
          ptr_nxt  = '0;
          unique case (in_kind)
            KIND_WRITE: begin
              send_nxt = 1'b0;
              if (col_ok && line_ok) begin
                state_nxt = ST_BASE;
              end
            end
            KIND_CLEAR: state_nxt = ST_CLEAR;
            KIND_SEND: begin
              send_nxt = 1'b1;
              if (line_ok) begin
                state_nxt = ST_BASE;
              end
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_BASE: begin
        if (cnt_r == '0) begin
          head_nxt  = HD_LEAD0;
          state_nxt = send_r ? ST_HEAD : ST_WRITE;
        end else begin
          ptr_nxt = sum_s;
          cnt_nxt = cnt_r - 3'd1;
        end
      end
      ST_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = sum_s[AddrW-1:0];
        ram_wdata = clcd_glyph(code_r);
        state_nxt = ST_IDLE;
      end
      ST_HEAD: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b0;
          unique case (head_r)
            HD_LEAD0: out_byte_nxt = CMD_LEAD;
            HD_POS:   out_byte_nxt = CMD_POS;
            HD_BASE:  out_byte_nxt = 8'(ptr_r);
            HD_LEAD1: out_byte_nxt = CMD_LEAD;
            HD_LEN:   out_byte_nxt = CMD_LEN;
            HD_WIDTH: out_byte_nxt = 8'(w_s);
            default:  out_byte_nxt = CMD_LEAD;
          endcase
          if (head_r == HD_WIDTH) begin
            cidx_nxt  = '0;
            state_nxt = ST_ROW;
          end else begin
            head_nxt = clcd_head_t'(head_r + 3'd1);
          end
        end
      end
      ST_ROW: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = ram_rdata;
          out_last_nxt  = (cidx_r == w_s - ColW'(1));
          if (cidx_r == w_s - ColW'(1)) begin
            state_nxt = ST_IDLE;
          end else begin
            cidx_nxt = cidx_r + ColW'(1);
            ptr_nxt  = sum_s;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      head_r      <= HD_LEAD0;
      ptr_r       <= '0;
      cnt_r       <= '0;
      cidx_r      <= '0;
      send_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cols_r      <= 5'd16;
      rows_r      <= 3'd2;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      ptr_r       <= ptr_nxt;
      cnt_r       <= cnt_nxt;
      cidx_r      <= cidx_nxt;
      send_r      <= send_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_COLS: cols_r <= cfg_wdata;
          CFG_ROWS: rows_r <= cfg_wdata[2:0];
          default:  ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    col_r      <= col_nxt;
    code_r     <= code_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  // The read address follows the next pointer, so the registered read data
  // always holds the entry the pointer names.
  clcd_frame_ram #(
    .Depth(Depth),
    .AddrW(AddrW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ptr_nxt[AddrW-1:0]),
    .rdata(ram_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule
